// ===== rtl/sha1md_pkg.sv =====
// ---------------------------------------------------------------------------
// sha1md_pkg
// Types, constants and round functions shared by the SHA-1 digest block.
// ---------------------------------------------------------------------------
package sha1md_pkg;

	localparam int LEN_BITS_DEF = 64;
	localparam int WORD_W       = 32;
	localparam int WIN_DEPTH    = 16;
	localparam int WIN_AW       = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	typedef enum logic [1:0] {
		GRP_CH  = 2'd0,
		GRP_P1  = 2'd1,
		GRP_MAJ = 2'd2,
		GRP_P2  = 2'd3
	} rgrp_t;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_RND [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_f(rgrp_t grp, logic [31:0] b,
		logic [31:0] c, logic [31:0] d);
		logic [31:0] r;
		unique case (grp)
			GRP_CH:  r = (b & c) | (~b & d);
			GRP_MAJ: r = (b & c) | (b & d) | (c & d);
			default: r = b ^ c ^ d;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/sha1_message_digest.sv =====
// ---------------------------------------------------------------------------
// sha1_message_digest
// Byte-serial SHA-1: packs bytes into a 16-word window RAM, runs the
// 80-round compression out of that RAM, pads and emits five digest words.
// ---------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  msg     | in        | msg_item_t  | msg_valid / msg_stall
//  dig     | out       | dig_item_t  | dig_valid / dig_stall
//
//  message bytes are taken only in the idle state; the 64th byte of a
//  block starts a compression, each round a read state then a calc state.
//  an end marker adds the padding writes and one or two compressions,
//  a load of the digest, then five word transfers.
//  asynchronous reset returns the chaining words to their initial values.
//  a new message may stream in while the digest is still being drained.
// ---------------------------------------------------------------------------
module sha1_message_digest #(
	parameter int LENGTH_COUNTER_BITS = sha1md_pkg::LEN_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  sha1md_pkg::msg_item_t msg,
	output logic                  dig_valid,
	input  logic                  dig_stall,
	output sha1md_pkg::dig_item_t dig
);

	localparam int CW = LENGTH_COUNTER_BITS;
	localparam int AW = sha1md_pkg::WIN_AW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PAD  = 7'b0000010,
		ST_LOAD = 7'b0000100,
		ST_RDB  = 7'b0001000,
		ST_CALC = 7'b0010000,
		ST_ADD  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [6:0]      t_q;
	logic [AW-1:0]   wp_q;
	logic            pfirst_q;
	logic            plen_q;
	logic            eom_q;
	logic            pad2_q;
	logic            fin_q;
	logic            obusy_q;
	logic [2:0]      oidx_q;
	logic [31:0]     h_q [5];
	logic [31:0]     wk_q [5];
	logic [31:0]     dig_q [5];
	logic [23:0]     word_q;
	logic [31:0]     w16_q;
	logic [31:0]     w14_q;

	logic            ram_we;
	logic [AW-1:0]   ram_wa;
	logic [31:0]     ram_wd;
	logic [AW-1:0]   ram_ra0;
	logic [AW-1:0]   ram_ra1;
	logic [31:0]     ram_rd0;
	logic [31:0]     ram_rd1;

	logic            in_xfer;
	logic            out_xfer;
	logic [AW-1:0]   pad_addr;
	logic            pad_len;
	logic [31:0]     pad_word;
	logic [63:0]     bit_len;
	logic [6:0]      t_nx;
	logic [31:0]     wt;
	logic [31:0]     f_val;
	logic [31:0]     rnd_sum;
	sha1md_pkg::rgrp_t grp;

	assign in_xfer   = msg_valid && !msg_stall;
	assign out_xfer  = dig_valid && !dig_stall;
	assign msg_stall = (state_q != ST_IDLE);

	assign dig_valid       = obusy_q;
	assign dig.digest_word = dig_q[0];
	assign dig.word_index  = oidx_q;
	assign dig.last_word   = (oidx_q == 3'd4);

	// padding words
	assign bit_len  = 64'(cnt_q) << 3;
	assign pad_addr = pfirst_q ? cnt_q[5:2] : wp_q;
	assign pad_len  = pfirst_q ? (cnt_q[5:0] < 6'd56) : plen_q;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: pad_word = {sha1md_pkg::PAD_BYTE, 24'h0};
			2'd1: pad_word = {word_q[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
			2'd2: pad_word = {word_q[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
			default: pad_word = {word_q[23:0], sha1md_pkg::PAD_BYTE};
		endcase
	end

	// round datapath
	assign t_nx = t_q + 7'd1;

	always_comb begin
		if (t_q < 7'd20) begin
			grp = sha1md_pkg::GRP_CH;
		end else if (t_q < 7'd40) begin
			grp = sha1md_pkg::GRP_P1;
		end else if (t_q < 7'd60) begin
			grp = sha1md_pkg::GRP_MAJ;
		end else begin
			grp = sha1md_pkg::GRP_P2;
		end
	end

	always_comb begin
		logic [31:0] x;
		x = ram_rd0 ^ ram_rd1 ^ w14_q ^ w16_q;
		wt = (t_q < 7'd16) ? w16_q : {x[30:0], x[31]};
	end

	assign f_val   = sha1md_pkg::round_f(grp, wk_q[1], wk_q[2], wk_q[3]);
	assign rnd_sum = {wk_q[0][26:0], wk_q[0][31:27]} + f_val + wk_q[4] + wt
		+ sha1md_pkg::K_RND[grp];

	// window ram access
	always_comb begin
		ram_we  = 1'b0;
		ram_wa  = cnt_q[5:2];
		ram_wd  = {word_q, msg.data_byte};
		ram_ra0 = t_q[3:0];
		ram_ra1 = t_q[3:0] + AW'(2);
		unique case (state_q)
			ST_IDLE: begin
				ram_we = in_xfer && msg.carries_byte && (cnt_q[1:0] == 2'd3);
			end
			ST_PAD: begin
				ram_we = 1'b1;
				ram_wa = pad_addr;
				if (pfirst_q) begin
					ram_wd = pad_word;
				end else if (pad_len && pad_addr == AW'(14)) begin
					ram_wd = bit_len[63:32];
				end else if (pad_len && pad_addr == AW'(15)) begin
					ram_wd = bit_len[31:0];
				end else begin
					ram_wd = '0;
				end
			end
			ST_LOAD: begin
				ram_ra0 = '0;
				ram_ra1 = AW'(2);
			end
			ST_RDB: begin
				ram_ra0 = t_q[3:0] + AW'(13);
				ram_ra1 = t_q[3:0] + AW'(8);
			end
			ST_CALC: begin
				ram_we  = (t_q >= 7'd16);
				ram_wa  = t_q[3:0];
				ram_wd  = wt;
				ram_ra0 = t_nx[3:0];
				ram_ra1 = t_nx[3:0] + AW'(2);
			end
			ST_ADD, ST_FIN: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	sha1md_ram #(
		.WIDTH (sha1md_pkg::WORD_W),
		.DEPTH (sha1md_pkg::WIN_DEPTH)
	) u_win (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_wa),
		.wdata  (ram_wd),
		.raddr0 (ram_ra0),
		.raddr1 (ram_ra1),
		.rdata0 (ram_rd0),
		.rdata1 (ram_rd1)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			t_q      <= '0;
			wp_q     <= '0;
			pfirst_q <= 1'b0;
			plen_q   <= 1'b0;
			eom_q    <= 1'b0;
			pad2_q   <= 1'b0;
			fin_q    <= 1'b0;
			obusy_q  <= 1'b0;
			oidx_q   <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sha1md_pkg::H_INIT[i];
			end
		end else begin
			if (out_xfer) begin
				if (oidx_q == 3'd4) begin
					obusy_q <= 1'b0;
				end
				oidx_q <= oidx_q + 3'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (msg.carries_byte) begin
							cnt_q <= cnt_q + CW'(1);
							if (cnt_q[5:0] == 6'd63) begin
								state_q <= ST_LOAD;
								eom_q   <= msg.end_of_message;
							end else if (msg.end_of_message) begin
								state_q  <= ST_PAD;
								pfirst_q <= 1'b1;
							end
						end else if (msg.end_of_message) begin
							state_q  <= ST_PAD;
							pfirst_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					pfirst_q <= 1'b0;
					plen_q   <= pad_len;
					wp_q     <= pad_addr + AW'(1);
					if (pad_addr == AW'(15)) begin
						state_q <= ST_LOAD;
						if (pad_len) begin
							fin_q <= 1'b1;
						end else begin
							pad2_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					t_q     <= '0;
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (t_q == 7'd79) begin
						t_q     <= '0;
						state_q <= ST_ADD;
					end else begin
						t_q     <= t_nx;
						state_q <= ST_RDB;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 5; i++) begin
						h_q[i] <= h_q[i] + wk_q[i];
					end
					if (fin_q) begin
						state_q <= ST_FIN;
					end else if (eom_q) begin
						eom_q    <= 1'b0;
						pfirst_q <= 1'b1;
						state_q  <= ST_PAD;
					end else if (pad2_q) begin
						pad2_q   <= 1'b0;
						pfirst_q <= 1'b0;
						plen_q   <= 1'b1;
						wp_q     <= '0;
						state_q  <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!obusy_q) begin
						obusy_q <= 1'b1;
						oidx_q  <= '0;
						cnt_q   <= '0;
						fin_q   <= 1'b0;
						state_q <= ST_IDLE;
						for (int i = 0; i < 5; i++) begin
							h_q[i] <= sha1md_pkg::H_INIT[i];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && msg.carries_byte) begin
			word_q <= {word_q[15:0], msg.data_byte};
		end
		if (state_q == ST_RDB) begin
			w16_q <= ram_rd0;
			w14_q <= ram_rd1;
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 5; i++) begin
				wk_q[i] <= h_q[i];
			end
		end else if (state_q == ST_CALC) begin
			wk_q[0] <= rnd_sum;
			wk_q[1] <= wk_q[0];
			wk_q[2] <= {wk_q[1][1:0], wk_q[1][31:2]};
			wk_q[3] <= wk_q[2];
			wk_q[4] <= wk_q[3];
		end
		if (state_q == ST_FIN && !obusy_q) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= h_q[i];
			end
		end else if (out_xfer) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	// checks
	a_dig_contig: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig.word_index != 3'd0 |-> $past(dig_valid))
		else $error("digest words not contiguous");

	a_blk_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && msg.carries_byte && cnt_q[5:0] == 6'd63 |=> state_q == ST_LOAD)
		else $error("full block did not start compression");

	a_no_rw_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && ram_we |-> ram_wa != ram_ra0 && ram_wa != ram_ra1)
		else $error("schedule write collides with read");

	a_fin_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !obusy_q |=> dig_valid && dig.word_index == 3'd0)
		else $error("digest not presented after finish");

endmodule

// ===== rtl/sha1md_ram.sv =====
// ---------------------------------------------------------------------------
// sha1md_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module sha1md_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule
